// ===== rtl/sfla_pkg.sv =====
// Package for the slab free-list allocator: field widths, register indexes
// and the command/status structs between controller and datapath.
// No dependencies.
package sfla_pkg;

  localparam int ADDR_W      = 32;
  localparam int SLAB_W      = 17;
  localparam int REQ_W       = 17;
  localparam int ALIGN_W     = 4;
  localparam int EFF_W       = 18;
  localparam int CNT_OUT_W   = 11;
  localparam int SIZE_OUT_W  = 17;
  localparam int BYTES_OUT_W = 27;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;
  localparam int DIV_CNT_W   = 5;

  localparam logic [SIZE_OUT_W-1:0]  SLOT_BYTES_SAT = '1;
  localparam logic [63:0]            USED_BYTES_SAT = 64'h7FF_FFFF;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    REG_POOL_BASE = 3'd0,
    REG_SLAB_BYTES = 3'd1,
    REG_REQ_SLOT = 3'd2,
    REG_ALIGN = 3'd3,
    REG_INIT_SLAB = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic accept;
    logic setup;
    logic load_slots;
    logic take_slab;
    logic pop;
    logic latch_pop;
    logic grant_fresh;
    logic push;
    logic fail;
    logic calc_used;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_release;
    logic push_ok;
    logic has_freed;
    logic has_fresh;
    logic can_take;
    logic init_ok;
    logic div_busy;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== rtl/sfla_req_if.sv =====
// Request channel: one word is a command and the address to release.
// Depends on sfla_pkg for field widths.
interface sfla_req_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [sfla_pkg::ADDR_W-1:0] slot_address;

  modport source (output valid, output command, output slot_address, input ready);
  modport sink   (input valid, input command, input slot_address, output ready);
endinterface

// ===== rtl/sfla_rsp_if.sv =====
// Response channel: one word per request with the grant and the counts.
// Depends on sfla_pkg for field widths.
interface sfla_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [sfla_pkg::ADDR_W-1:0]      granted_address;
  logic                            success;
  logic [sfla_pkg::CNT_OUT_W-1:0]   free_slots;
  logic [sfla_pkg::CNT_OUT_W-1:0]   total_slots;
  logic [sfla_pkg::CNT_OUT_W-1:0]   used_slots;
  logic [sfla_pkg::SIZE_OUT_W-1:0]  slot_bytes;
  logic [sfla_pkg::BYTES_OUT_W-1:0] used_bytes;

  modport source (output valid, output granted_address, output success, output free_slots,
                  output total_slots, output used_slots, output slot_bytes,
                  output used_bytes, input ready);
  modport sink   (input valid, input granted_address, input success, input free_slots,
                  input total_slots, input used_slots, input slot_bytes,
                  input used_bytes, output ready);
endinterface

// ===== rtl/sfla_div.sv =====
// Restoring divider, one quotient bit per cycle: slab bytes over slot bytes.
// Depends on sfla_pkg for operand widths.
module sfla_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sfla_pkg::SLAB_W-1:0]   dividend,
  input  logic [sfla_pkg::EFF_W-1:0]    divisor,
  output logic                          busy,
  output logic [sfla_pkg::SLAB_W-1:0]   quotient
);

  logic [sfla_pkg::DIV_CNT_W-1:0] cnt;
  logic [sfla_pkg::SLAB_W-1:0]    num;
  logic [sfla_pkg::EFF_W-1:0]     rem;
  logic [sfla_pkg::EFF_W-1:0]     dvs;
  logic [sfla_pkg::EFF_W:0]       trial;
  logic                           ge;

  always_comb begin
    trial = {rem, num[sfla_pkg::SLAB_W-1]};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= sfla_pkg::DIV_CNT_W'(sfla_pkg::SLAB_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? sfla_pkg::EFF_W'(trial - {1'b0, dvs}) : trial[sfla_pkg::EFF_W-1:0];
      num <= {num[sfla_pkg::SLAB_W-2:0], ge};
    end
  end

  assign quotient = num;

endmodule

// ===== rtl/sfla_ctrl.sv =====
// Sequencer for the allocator: setup on the first word, then one
// allocate or release per word. Depends on sfla_pkg for command/status.
module sfla_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sfla_pkg::dp_status_t status,
  output sfla_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DIV  = 8'b0000_0010,
    ST_OFFS = 8'b0000_0100,
    ST_INIT = 8'b0000_1000,
    ST_EXEC = 8'b0001_0000,
    ST_POP  = 8'b0010_0000,
    ST_MUL  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   running, running_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    running_next = running;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (running) begin
            state_next = ST_EXEC;
          end else begin
            cmd.setup  = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (!status.div_busy) begin
          state_next = ST_OFFS;
        end
      end
      ST_OFFS: begin
        cmd.load_slots = 1'b1;
        state_next     = ST_INIT;
      end
      ST_INIT: begin
        cmd.take_slab = status.init_ok;
        running_next  = 1'b1;
        state_next    = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.is_release) begin
          if (status.push_ok) begin
            cmd.push = 1'b1;
          end else begin
            cmd.fail = 1'b1;
          end
          state_next = ST_MUL;
        end else if (status.has_freed) begin
          cmd.pop    = 1'b1;
          state_next = ST_POP;
        end else if (status.has_fresh) begin
          cmd.grant_fresh = 1'b1;
          state_next      = ST_MUL;
        end else if (status.can_take) begin
          cmd.take_slab = 1'b1;
        end else begin
          cmd.fail   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_POP: begin
        cmd.latch_pop = 1'b1;
        state_next    = ST_MUL;
      end
      ST_MUL: begin
        cmd.calc_used = 1'b1;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      running <= 1'b0;
    end else begin
      state   <= state_next;
      running <= running_next;
    end
  end

endmodule

// ===== rtl/sfla_dp.sv =====
// Allocator datapath: slot size, counters, slab walk, freed-slot stack
// memory and the response register. Depends on sfla_pkg and sfla_div.
module sfla_dp #(
  parameter int MAX_SLABS      = 16,
  parameter int MAX_SLOTS      = 1024,
  parameter int MIN_SLOT_BYTES = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sfla_pkg::ctrl_cmd_t              cmd,
  output sfla_pkg::dp_status_t             status,
  input  logic [sfla_pkg::ADDR_W-1:0]      pool_base,
  input  logic [sfla_pkg::SLAB_W-1:0]      slab_bytes,
  input  logic [sfla_pkg::REQ_W-1:0]       req_slot_bytes,
  input  logic [sfla_pkg::ALIGN_W-1:0]     align_log2,
  input  logic                             initial_slab,
  input  logic                             in_command,
  input  logic [sfla_pkg::ADDR_W-1:0]      in_slot_address,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sfla_pkg::ADDR_W-1:0]      out_granted_address,
  output logic                             out_success,
  output logic [sfla_pkg::CNT_OUT_W-1:0]   out_free_slots,
  output logic [sfla_pkg::CNT_OUT_W-1:0]   out_total_slots,
  output logic [sfla_pkg::CNT_OUT_W-1:0]   out_used_slots,
  output logic [sfla_pkg::SIZE_OUT_W-1:0]  out_slot_bytes,
  output logic [sfla_pkg::BYTES_OUT_W-1:0] out_used_bytes
);

  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int IW = $clog2(MAX_SLOTS);
  localparam int SW = $clog2(MAX_SLABS + 1);
  localparam int PW = CW + sfla_pkg::EFF_W;
  localparam int OW = sfla_pkg::SLAB_W + sfla_pkg::EFF_W;
  localparam int TW = sfla_pkg::SLAB_W + 1;

  // item
  logic                        item_cmd;
  logic [sfla_pkg::ADDR_W-1:0] item_addr;

  // setup results
  logic [sfla_pkg::EFF_W-1:0]  eff;
  logic [sfla_pkg::SLAB_W-1:0] slots;
  logic [sfla_pkg::SLAB_W-1:0] run_slab;
  logic [sfla_pkg::ADDR_W-1:0] top_offset;
  logic                        run_init;

  // control state
  logic [CW-1:0]               depth;
  logic [CW-1:0]               fresh_left;
  logic [CW-1:0]               free_count;
  logic [CW-1:0]               total_count;
  logic [SW-1:0]               slabs_taken;
  logic [sfla_pkg::ADDR_W-1:0] fresh_next;
  logic [sfla_pkg::ADDR_W-1:0] slab_addr;

  // result
  logic [sfla_pkg::ADDR_W-1:0] granted;
  logic                        ok;
  logic [CW-1:0]               used_r;
  logic [PW-1:0]               prod;
  logic [sfla_pkg::ADDR_W-1:0] rdata;

  logic [sfla_pkg::ADDR_W-1:0] stack_mem [MAX_SLOTS];

  logic [sfla_pkg::EFF_W-1:0]  s_min;
  logic [sfla_pkg::EFF_W-1:0]  align_one;
  logic [sfla_pkg::EFF_W-1:0]  eff_calc;
  logic [sfla_pkg::SLAB_W-1:0] quotient;
  logic                        div_busy;
  logic [OW-1:0]               offs_prod;
  logic [CW-1:0]               depth_m1;
  logic [CW-1:0]               used_calc;
  logic [63:0]                 prod_ext;

  always_comb begin
    s_min     = (req_slot_bytes < sfla_pkg::REQ_W'(MIN_SLOT_BYTES))
                ? sfla_pkg::EFF_W'(MIN_SLOT_BYTES) : sfla_pkg::EFF_W'(req_slot_bytes);
    align_one = sfla_pkg::EFF_W'(1) << align_log2;
    eff_calc  = (s_min + align_one - sfla_pkg::EFF_W'(1)) & ~(align_one - sfla_pkg::EFF_W'(1));
    offs_prod = OW'(quotient - 1'b1) * OW'(eff);
    depth_m1  = depth - 1'b1;
    used_calc = (total_count > free_count) ? total_count - free_count : '0;
    prod_ext  = 64'(prod);
  end

  sfla_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.setup),
    .dividend (slab_bytes),
    .divisor  (eff_calc),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_comb begin
    status.is_release = (item_cmd == sfla_pkg::CMD_RELEASE);
    status.push_ok    = (item_addr != '0) && (free_count < CW'(MAX_SLOTS))
                        && (depth < CW'(MAX_SLOTS));
    status.has_freed  = (depth != '0);
    status.has_fresh  = (fresh_left != '0);
    status.can_take   = (slabs_taken < SW'(MAX_SLABS)) && (slots != '0)
                        && (TW'(total_count) + TW'(slots) <= TW'(MAX_SLOTS));
    status.init_ok    = run_init && (slots != '0) && (TW'(slots) <= TW'(MAX_SLOTS));
    status.div_busy   = div_busy;
    status.out_busy   = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_cmd  <= in_command;
      item_addr <= in_slot_address;
    end
    if (cmd.setup) begin
      eff      <= eff_calc;
      run_slab <= slab_bytes;
      run_init <= initial_slab;
    end
    if (cmd.load_slots) begin
      slots      <= quotient;
      top_offset <= offs_prod[sfla_pkg::ADDR_W-1:0];
    end
    if (cmd.setup) begin
      fresh_next <= '0;
      slab_addr  <= pool_base;
    end else if (cmd.take_slab) begin
      fresh_next <= slab_addr + top_offset;
      slab_addr  <= slab_addr + sfla_pkg::ADDR_W'(run_slab);
    end else if (cmd.grant_fresh) begin
      fresh_next <= fresh_next - sfla_pkg::ADDR_W'(eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth       <= '0;
      fresh_left  <= '0;
      free_count  <= '0;
      total_count <= '0;
      slabs_taken <= '0;
    end else if (cmd.setup) begin
      depth       <= '0;
      fresh_left  <= '0;
      free_count  <= '0;
      total_count <= '0;
      slabs_taken <= '0;
    end else if (cmd.take_slab) begin
      fresh_left  <= CW'(slots);
      free_count  <= free_count + CW'(slots);
      total_count <= total_count + CW'(slots);
      slabs_taken <= slabs_taken + 1'b1;
    end else if (cmd.pop) begin
      depth <= depth_m1;
      if (free_count != '0) begin
        free_count <= free_count - 1'b1;
      end
    end else if (cmd.grant_fresh) begin
      fresh_left <= fresh_left - 1'b1;
      if (free_count != '0) begin
        free_count <= free_count - 1'b1;
      end
    end else if (cmd.push) begin
      depth      <= depth + 1'b1;
      free_count <= free_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[depth[IW-1:0]] <= item_addr;
    end
    if (cmd.pop) begin
      rdata <= stack_mem[depth_m1[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fail) begin
      granted <= '0;
      ok      <= 1'b0;
    end else if (cmd.push) begin
      granted <= '0;
      ok      <= 1'b1;
    end else if (cmd.grant_fresh) begin
      granted <= fresh_next;
      ok      <= 1'b1;
    end else if (cmd.pop) begin
      ok <= 1'b1;
    end else if (cmd.latch_pop) begin
      granted <= rdata;
    end
    if (cmd.calc_used) begin
      used_r <= used_calc;
      prod   <= PW'(used_calc) * PW'(eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_granted_address <= granted;
      out_success         <= ok;
      out_free_slots      <= sfla_pkg::CNT_OUT_W'(free_count);
      out_total_slots     <= sfla_pkg::CNT_OUT_W'(total_count);
      out_used_slots      <= sfla_pkg::CNT_OUT_W'(used_r);
      out_slot_bytes      <= (eff > sfla_pkg::EFF_W'(sfla_pkg::SLOT_BYTES_SAT))
                             ? sfla_pkg::SLOT_BYTES_SAT : eff[sfla_pkg::SIZE_OUT_W-1:0];
      out_used_bytes      <= (prod_ext > sfla_pkg::USED_BYTES_SAT)
                             ? sfla_pkg::USED_BYTES_SAT[sfla_pkg::BYTES_OUT_W-1:0]
                             : prod_ext[sfla_pkg::BYTES_OUT_W-1:0];
    end
  end

  // free slots are always the stacked ones plus the fresh ones
  a_free_split: assert property (@(posedge clk) disable iff (rst)
    (CW+1)'(free_count) == (CW+1)'(depth) + (CW+1)'(fresh_left))
    else $error("free count out of step with stack depth and fresh slots");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total_count <= CW'(MAX_SLOTS))
    else $error("total slots beyond pool limit");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> depth < CW'(MAX_SLOTS))
    else $error("push onto full stack");

  a_pop_latch: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> cmd.latch_pop)
    else $error("popped word not captured");

endmodule

// ===== rtl/slab_free_list_allocator_top.sv =====
// Top level of the slab free-list allocator: register file, controller
// and datapath. Depends on sfla_pkg, sfla_req_if, sfla_rsp_if, sfla_ctrl, sfla_dp.
//
// Usage: requests arrive as words on req (command 0 allocates, 1 releases
// slot_address); each request yields one word on rsp with the granted address,
// success flag, slot counts, slot size and bytes in use.
// Registers sit on the APB port at 4*i: pool_base, slab_bytes,
// requested_slot_bytes, alignment_log2, initial_slab; write them only while idle.
// The first request after reset runs setup: slot size, a serial divide for
// slots per slab, the slab offset multiply and the optional slab zero.
// After that a release, failed allocate or grant of a fresh slot passes the
// execute, multiply and done states before the response word is valid; a
// grant from the freed stack adds a pop state (one registered stack memory
// read) and opening a new slab adds a pass through execute; the sequencer
// handles one request at a time, so the next request is taken only after the
// previous response is loaded into the output register.
// req.ready stays high while a response waits in the output register; if rsp
// is stalled the next response is held and req.ready drops until it drains.
// Reset restores the register values and returns the pool to its setup state;
// the freed stack is not cleared and needs no sweep.
module slab_free_list_allocator_top #(
  parameter int MAX_SLABS      = 16,
  parameter int MAX_SLOTS      = 1024,
  parameter int MIN_SLOT_BYTES = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  sfla_req_if.sink                     req,
  sfla_rsp_if.source                   rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfla_pkg::PADDR_W-1:0] paddr,
  input  logic [sfla_pkg::PDATA_W-1:0] pwdata,
  output logic [sfla_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  logic [sfla_pkg::ADDR_W-1:0]  pool_base;
  logic [sfla_pkg::SLAB_W-1:0]  slab_bytes;
  logic [sfla_pkg::REQ_W-1:0]   req_slot_bytes;
  logic [sfla_pkg::ALIGN_W-1:0] align_log2;
  logic                         initial_slab;
  sfla_pkg::reg_idx_t           reg_idx;
  logic                         wr_en;

  sfla_pkg::ctrl_cmd_t  cmd;
  sfla_pkg::dp_status_t status;

  assign pready  = 1'b1;
  assign reg_idx = sfla_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base      <= 32'd65536;
      slab_bytes     <= 17'd4096;
      req_slot_bytes <= 17'd64;
      align_log2     <= 4'd3;
      initial_slab   <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        sfla_pkg::REG_POOL_BASE:  pool_base      <= pwdata;
        sfla_pkg::REG_SLAB_BYTES: slab_bytes     <= pwdata[sfla_pkg::SLAB_W-1:0];
        sfla_pkg::REG_REQ_SLOT:   req_slot_bytes <= pwdata[sfla_pkg::REQ_W-1:0];
        sfla_pkg::REG_ALIGN:      align_log2     <= pwdata[sfla_pkg::ALIGN_W-1:0];
        sfla_pkg::REG_INIT_SLAB:  initial_slab   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sfla_pkg::REG_POOL_BASE:  prdata = pool_base;
      sfla_pkg::REG_SLAB_BYTES: prdata = sfla_pkg::PDATA_W'(slab_bytes);
      sfla_pkg::REG_REQ_SLOT:   prdata = sfla_pkg::PDATA_W'(req_slot_bytes);
      sfla_pkg::REG_ALIGN:      prdata = sfla_pkg::PDATA_W'(align_log2);
      sfla_pkg::REG_INIT_SLAB:  prdata = sfla_pkg::PDATA_W'(initial_slab);
      default:                  prdata = '0;
    endcase
  end

  sfla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sfla_dp #(
    .MAX_SLABS      (MAX_SLABS),
    .MAX_SLOTS      (MAX_SLOTS),
    .MIN_SLOT_BYTES (MIN_SLOT_BYTES)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .pool_base           (pool_base),
    .slab_bytes          (slab_bytes),
    .req_slot_bytes      (req_slot_bytes),
    .align_log2          (align_log2),
    .initial_slab        (initial_slab),
    .in_command          (req.command),
    .in_slot_address     (req.slot_address),
    .out_valid           (rsp.valid),
    .out_ready           (rsp.ready),
    .out_granted_address (rsp.granted_address),
    .out_success         (rsp.success),
    .out_free_slots      (rsp.free_slots),
    .out_total_slots     (rsp.total_slots),
    .out_used_slots      (rsp.used_slots),
    .out_slot_bytes      (rsp.slot_bytes),
    .out_used_bytes      (rsp.used_bytes)
  );

endmodule
